>>> rtl/core/bstg_pkg.sv
package bstg_pkg;

    localparam int unsigned TABLE_LAST = 6;
    localparam logic [7:0]  HOLD_POLLS_RESET = 8'd10;

    typedef struct packed {
        logic up_pressed;
        logic down_pressed;
        logic poll_strobe;
    } t_in_item;

    typedef struct packed {
        logic       note_changed;
        logic [9:0] note_hertz;
        logic [2:0] note_number;
        logic       tone_out;
    } t_out_item;

    function automatic logic [15:0] note_compare(input logic [2:0] idx);
        logic [15:0] v;
        unique case (idx)
            3'd0:    v = 16'h77BB;
            3'd1:    v = 16'h6AA8;
            3'd2:    v = 16'h5EFC;
            3'd3:    v = 16'h59AC;
            3'd4:    v = 16'h4FEC;
            3'd5:    v = 16'h472F;
            default: v = 16'h3F74;
        endcase
        return v;
    endfunction

    function automatic logic [9:0] note_freq(input logic [2:0] idx);
        logic [9:0] v;
        unique case (idx)
            3'd0:    v = 10'd522;
            3'd1:    v = 10'd586;
            3'd2:    v = 10'd658;
            3'd3:    v = 10'd697;
            3'd4:    v = 10'd782;
            3'd5:    v = 10'd878;
            default: v = 10'd985;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/button_selected_tone_generator.sv
// Button-selected square-wave tone generator.
// Slave stream (i_s_*): one item per timer tick, tdata bit 0 poll strobe,
// bit 1 down button, bit 2 up button. Each accepted item yields exactly one
// result item on the master stream (o_m_*): tdata bit 0 tone level,
// bits 3:1 note number, bits 13:4 note frequency in hertz, bit 14 note
// changed flag, bit 15 zero.
// Config channel (i_cfg_*): hold_polls, the polls a button must stay held
// before each note step; always ready, write only while idle.
// Each result is registered into the result register, or into the skid register while the receiver holds a result.
// Throughput: one item per cycle while o_s_tready is high; the whole update of hold counters, note
// index and compare counter is one combinational pass into the state
// registers.
// A two-entry output buffer (result register plus skid register) lets one
// more item in while a result waits; with both full, o_s_tready drops until
// the receiver takes a result.
// Reset (synchronous, active low) clears counters, note, tone, buffers and
// sets hold_polls to 10.
module button_selected_tone_generator #(
    parameter int unsigned NOTE_COUNT  = 7,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // poll_strobe, down_pressed, up_pressed, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // tone_out, note_number[3], note_hertz[10],
                                     // note_changed, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned NOTE_W = $clog2(NOTE_COUNT);

    bstg_pkg::t_in_item  s_item;
    bstg_pkg::t_out_item n_item;
    bstg_pkg::t_out_item r_out;
    bstg_pkg::t_out_item r_skid;

    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic [7:0]             r_hold_polls;
    logic [7:0]             r_down_hold;
    logic [7:0]             r_up_hold;
    logic [NOTE_W-1:0]      r_note;
    logic [COUNT_WIDTH-1:0] r_tick;
    logic                   r_tone;

    logic [7:0]             n_down_hold;
    logic [7:0]             n_up_hold;
    logic [NOTE_W-1:0]      n_note;
    logic [COUNT_WIDTH-1:0] n_tick;
    logic                   n_tone;
    logic                   n_changed;

    logic                    s_acc;
    logic                    m_pop;
    logic                    out_free;
    logic [4:0]              note_ext;
    logic [2:0]              tab_idx;
    logic [4:0]              n_note_ext;
    logic [2:0]              n_tab_idx;
    logic [COUNT_WIDTH+15:0] cmp_ext;
    logic [COUNT_WIDTH-1:0]  cmp_val;

    assign s_item      = bstg_pkg::t_in_item'(i_s_tdata[2:0]);
    assign o_s_tready  = !r_skid_valid;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_pop       = r_out_valid && i_m_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_out};

    assign note_ext = 5'(r_note);
    assign tab_idx  = (note_ext >= 5'(bstg_pkg::TABLE_LAST)) ?
                      3'(bstg_pkg::TABLE_LAST) : note_ext[2:0];
    assign cmp_ext  = {{COUNT_WIDTH{1'b0}}, bstg_pkg::note_compare(tab_idx)};
    assign cmp_val  = cmp_ext[COUNT_WIDTH-1:0];

    always_comb begin
        n_down_hold = r_down_hold;
        n_up_hold   = r_up_hold;
        n_note      = r_note;
        n_changed   = 1'b0;
        if (s_item.poll_strobe) begin
            if (s_item.down_pressed) begin
                if (r_down_hold < r_hold_polls) begin
                    n_down_hold = r_down_hold + 8'd1;
                end else begin
                    n_down_hold = '0;
                    if (r_note != '0) begin
                        n_note    = r_note - NOTE_W'(1);
                        n_changed = 1'b1;
                    end
                end
            end else begin
                n_down_hold = '0;
                if (s_item.up_pressed) begin
                    if (r_up_hold < r_hold_polls) begin
                        n_up_hold = r_up_hold + 8'd1;
                    end else begin
                        n_up_hold = '0;
                        if (r_note < NOTE_W'(NOTE_COUNT - 1)) begin
                            n_note    = r_note + NOTE_W'(1);
                            n_changed = 1'b1;
                        end
                    end
                end else begin
                    n_up_hold = '0;
                end
            end
        end

        n_tone = r_tone;
        priority if (n_changed) begin
            n_tick = '0;
        end else if (r_tick >= cmp_val) begin
            n_tone = !r_tone;
            n_tick = '0;
        end else begin
            n_tick = r_tick + COUNT_WIDTH'(1);
        end
    end

    assign n_note_ext = 5'(n_note);
    assign n_tab_idx  = (n_note_ext >= 5'(bstg_pkg::TABLE_LAST)) ?
                        3'(bstg_pkg::TABLE_LAST) : n_note_ext[2:0];

    always_comb begin
        n_item.tone_out     = n_tone;
        n_item.note_number  = n_note_ext[2:0];
        n_item.note_hertz   = bstg_pkg::note_freq(n_tab_idx);
        n_item.note_changed = n_changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_polls <= bstg_pkg::HOLD_POLLS_RESET;
            r_down_hold  <= '0;
            r_up_hold    <= '0;
            r_note       <= '0;
            r_tick       <= '0;
            r_tone       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hold_polls <= i_cfg_data;
            end
            if (s_acc) begin
                r_down_hold <= n_down_hold;
                r_up_hold   <= n_up_hold;
                r_note      <= n_note;
                r_tick      <= n_tick;
                r_tone      <= n_tone;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (s_acc) begin
                if (out_free) begin
                    r_out       <= n_item;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_item;
                    r_skid_valid <= 1'b1;
                end
            end else if (m_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        5'(r_note) <= 5'(NOTE_COUNT - 1))
        else $error("note index beyond the last note");

    a_no_poll_note_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !s_item.poll_strobe) |=> $stable(r_note))
        else $error("note changed on an item without poll strobe");

    a_change_clears_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_changed) |=> (r_tick == '0))
        else $error("compare counter not cleared on note change");

endmodule

>>> dv/tb_button_selected_tone_generator.sv
module tb_button_selected_tone_generator;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_SETTLE = 4;
    localparam int unsigned LONG_RUN     = 40;

    typedef enum logic [1:0] {
        STEP_TICK,
        STEP_CFG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        logic [7:0] data;
        bit         fast;
    } t_step;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'd0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data  = 8'd0;

    button_selected_tone_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    logic [15:0] note_period [7] = '{16'h77BB, 16'h6AA8, 16'h5EFC, 16'h59AC,
                                     16'h4FEC, 16'h472F, 16'h3F74};
    logic [9:0]  note_hz     [7] = '{10'd522, 10'd586, 10'd658, 10'd697,
                                     10'd782, 10'd878, 10'd985};

    logic [7:0]  hold_limit = bstg_pkg::HOLD_POLLS_RESET;
    logic [7:0]  down_cnt   = 8'd0;
    logic [7:0]  up_cnt     = 8'd0;
    logic [2:0]  note_idx   = 3'd0;
    logic [15:0] tick_cnt   = 16'd0;
    logic        tone_lvl   = 1'b0;

    t_step                tick_plan [$];
    bstg_pkg::t_out_item  expected_tones [$];
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_count    = 0;
    int unsigned plan_hold   = bstg_pkg::HOLD_POLLS_RESET;

    bit          in_ack  = 1'b0;
    bit          cfg_ack = 1'b0;
    bit          out_ack = 1'b0;

    function automatic bstg_pkg::t_out_item tone_next(input bstg_pkg::t_in_item it);
        logic                changed;
        int unsigned         idx;
        bstg_pkg::t_out_item r;
        changed = 1'b0;
        if (it.poll_strobe) begin
            if (it.down_pressed) begin
                if (down_cnt < hold_limit) begin
                    down_cnt = down_cnt + 8'd1;
                end else begin
                    down_cnt = 8'd0;
                    if (note_idx > 0) begin
                        note_idx = note_idx - 3'd1;
                        changed  = 1'b1;
                    end
                end
            end else begin
                down_cnt = 8'd0;
                if (it.up_pressed) begin
                    if (up_cnt < hold_limit) begin
                        up_cnt = up_cnt + 8'd1;
                    end else begin
                        up_cnt = 8'd0;
                        if (note_idx < bstg_pkg::TABLE_LAST) begin
                            note_idx = note_idx + 3'd1;
                            changed  = 1'b1;
                        end
                    end
                end else begin
                    up_cnt = 8'd0;
                end
            end
        end
        idx = (note_idx > bstg_pkg::TABLE_LAST) ? bstg_pkg::TABLE_LAST : note_idx;
        if (changed) begin
            tick_cnt = 16'd0;
        end else if (tick_cnt >= note_period[idx]) begin
            tone_lvl = ~tone_lvl;
            tick_cnt = 16'd0;
        end else begin
            tick_cnt = tick_cnt + 16'd1;
        end
        r.tone_out     = tone_lvl;
        r.note_number  = note_idx;
        r.note_hertz   = note_hz[idx];
        r.note_changed = changed;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_tick(input logic poll, input logic dn, input logic up,
                            input bit fast = 1'b0);
        t_step s;
        s.kind = STEP_TICK;
        s.data = {5'd0, up, dn, poll};
        s.fast = fast;
        tick_plan.push_back(s);
    endtask

    task automatic add_hold_write(input logic [7:0] v);
        t_step s;
        s.kind = STEP_DRAIN;
        s.data = 8'd0;
        s.fast = 1'b0;
        tick_plan.push_back(s);
        s.kind = STEP_CFG;
        s.data = v;
        tick_plan.push_back(s);
        plan_hold = v;
    endtask

    // well-formed presses with random polling rate, some glitches and cut-short presses
    task automatic plan_presses(input int unsigned n);
        int unsigned added;
        int unsigned polls;
        int unsigned k;
        int unsigned j;
        int unsigned noise;
        logic        dn;
        logic        up;
        logic [1:0]  glitch;
        added = 0;
        while (added < n) begin
            case ($urandom_range(0, 7))
                0, 1, 2: {dn, up} = 2'b10;
                3, 4, 5: {dn, up} = 2'b01;
                6:       {dn, up} = 2'b11;
                default: {dn, up} = 2'b00;
            endcase
            polls = $urandom_range(1, 2 * plan_hold + 4);
            if ($urandom_range(0, 7) == 0)
                polls = $urandom_range(1, 3);
            for (k = 0; k < polls; k++) begin
                noise = $urandom_range(0, 2);
                for (j = 0; j < noise; j++) begin
                    add_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    added++;
                end
                if ($urandom_range(0, 15) == 0) begin
                    glitch = 2'($urandom_range(0, 3));
                    add_tick(1'b1, glitch[1], glitch[0]);
                end else begin
                    add_tick(1'b1, dn, up);
                end
                added++;
            end
            add_tick(1'b1, 1'b0, 1'b0);
            added++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // handshake tracking, prediction and result check
    always @(posedge i_clk) begin
        in_ack  = i_rst_n && i_s_tvalid && o_s_tready;
        cfg_ack = i_rst_n && i_cfg_valid && o_cfg_ready;
        out_ack = i_rst_n && o_m_tvalid && i_m_tready;
        if (out_ack) begin
            rx_count++;
            if (expected_tones.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_m_tdata);
                errors++;
            end else begin
                bstg_pkg::t_out_item exp_r;
                bstg_pkg::t_out_item got_r;
                exp_r = expected_tones.pop_front();
                got_r = bstg_pkg::t_out_item'(o_m_tdata[14:0]);
                check_field("tone_out", exp_r.tone_out, got_r.tone_out);
                check_field("note_number", exp_r.note_number, got_r.note_number);
                check_field("note_hertz", exp_r.note_hertz, got_r.note_hertz);
                check_field("note_changed", exp_r.note_changed, got_r.note_changed);
                check_field("tdata pad", 16'd0, o_m_tdata[15]);
            end
        end
        if (cfg_ack)
            hold_limit = i_cfg_data;
        if (in_ack)
            expected_tones.push_back(tone_next(bstg_pkg::t_in_item'(i_s_tdata[2:0])));
    end

    // sender
    t_step       cur_step;
    int unsigned gap_left   = 0;
    int unsigned mode_left  = 0;
    int unsigned settle_cnt = 0;
    bit          tx_busy    = 1'b1;
    bit          next_valid;
    bit          next_cfg;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            next_valid = i_s_tvalid && !in_ack;
            next_cfg   = i_cfg_valid && !cfg_ack;
            if (!next_valid && !next_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_plan.size() > 0) begin
                    cur_step = tick_plan[0];
                    case (cur_step.kind)
                        STEP_TICK: begin
                            i_s_tdata  <= cur_step.data;
                            next_valid = 1'b1;
                            void'(tick_plan.pop_front());
                            if (mode_left == 0) begin
                                mode_left = $urandom_range(20, 80);
                                tx_busy   = ($urandom_range(0, 3) != 0);
                            end
                            mode_left--;
                            gap_left = (cur_step.fast || !tx_busy) ? 0 : $urandom_range(0, 6);
                        end
                        STEP_CFG: begin
                            i_cfg_data <= cur_step.data;
                            next_cfg   = 1'b1;
                            void'(tick_plan.pop_front());
                        end
                        default: begin
                            // hold until every result is back, then let the block settle
                            if (expected_tones.size() == 0) begin
                                settle_cnt++;
                                if (settle_cnt >= DRAIN_SETTLE) begin
                                    settle_cnt = 0;
                                    void'(tick_plan.pop_front());
                                end
                            end else begin
                                settle_cnt = 0;
                            end
                        end
                    endcase
                end
            end
            i_s_tvalid  <= next_valid;
            i_cfg_valid <= next_cfg;
        end
    end

    // receiver
    int unsigned stall_left   = 0;
    int unsigned long_left    = 0;
    int unsigned rx_mode_left = 0;
    bit          rx_busy      = 1'b1;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (out_ack) begin
                if (rx_mode_left == 0) begin
                    rx_mode_left = $urandom_range(20, 80);
                    rx_busy      = ($urandom_range(0, 3) != 0);
                end
                rx_mode_left--;
                stall_left = rx_busy ? $urandom_range(0, 6) : 0;
                if (rx_count == 300 || rx_count == 1000)
                    long_left = 60;
            end
            if (long_left > 0) begin
                long_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned k;

        plan_presses(180);

        add_hold_write(8'd0);
        for (k = 0; k < 7; k++)
            add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 1'b0);
        for (k = 0; k < 6; k++)
            add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 1'b0);

        add_hold_write(8'd1);
        plan_presses(200);

        add_hold_write(8'd255);
        for (k = 0; k < 260; k++)
            add_tick(1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b0, 1'b0);
        for (k = 0; k < 260; k++)
            add_tick(1'b1, 1'b1, 1'b0);
        add_tick(1'b1, 1'b0, 1'b0);

        add_hold_write(8'd3);
        plan_presses(170);

        add_hold_write(8'($urandom_range(4, 20)));
        plan_presses(170);

        add_hold_write(8'd2);
        plan_presses(130);

        // climb to the top note, then run on without polling
        add_hold_write(8'd0);
        for (k = 0; k < 7; k++)
            add_tick(1'b1, 1'b0, 1'b1);
        for (k = 0; k < LONG_RUN; k++)
            add_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);

        while (tick_plan.size() > 0 || i_s_tvalid || i_cfg_valid || expected_tones.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
